// ----- rtl/core/lpht_pkg.sv -----
// ---------------------------------------------------------------------------
// lpht_pkg
// shared codes and widths of the linear-probing hash table
// ---------------------------------------------------------------------------
package lpht_pkg;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned HASH_W = 32;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned SLOT_W = 11;
    localparam int unsigned SOUT_W = 10;
    localparam int unsigned LIVE_W = 11;

    // commands
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOROOM   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DONE     = 3'd4;
    localparam logic [STAT_W-1:0] ST_END      = 3'd5;
    localparam logic [STAT_W-1:0] ST_BADSLOT  = 3'd6;

    // slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    typedef logic [HASH_W-1:0] t_hash;

endpackage

// ----- rtl/core/lpht_hash.sv -----
// ---------------------------------------------------------------------------
// lpht_hash
// one-at-a-time key hash, one byte per cycle, then a closing step
// ---------------------------------------------------------------------------
module lpht_hash
    import lpht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_done,
    output t_hash            o_hash
);

    function automatic t_hash f_step(input t_hash h, input logic [7:0] b);
        t_hash x;
        x = h + {24'd0, b};
        x = x + (x << 10);
        x = x ^ (x >> 6);
        return x;
    endfunction

    function automatic t_hash f_fin(input t_hash h);
        t_hash x;
        x = h + (h << 3);
        x = x ^ (x >> 11);
        x = x + (x << 15);
        return x;
    endfunction

    logic             r_busy;
    logic             r_done;
    t_hash            r_h;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_h    <= '0;
                r_key  <= i_key;
                r_len  <= i_len;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt != r_len) begin
                    r_h   <= f_step(r_h, r_key[7:0]);
                    r_key <= r_key >> 8;
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_h    <= f_fin(r_h);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;

endmodule

// ----- rtl/core/linear_probe_hash_table_unit.sv -----
// ---------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open-addressing hash table with linear probing and tombstones
// ---------------------------------------------------------------------------
// One command at a time. Lookup and insert first hash the key, then probe one
// slot a cycle (the mark and key memories are read one slot a cycle, next
// address issued while the current one is checked). Delete reads and checks
// the one given slot; next-entry scans one slot a cycle from its start slot.
// After reset and on erase-all the mark memory is cleared one slot a cycle,
// during which no command is taken. A finished result waits in an output
// register; the following command is accepted meanwhile.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 1024,
    parameter int unsigned KEY_BYTES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,  // key_value, key_bytes, slot_in
    input  logic [2:0]  i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // slot_out, live_count
    output logic [2:0]  o_m_axis_tuser   // status
);

    localparam int unsigned AW = $clog2(TABLE_SLOTS);
    localparam int unsigned KW = 8 * KEY_BYTES;
    localparam int unsigned DW = HASH_W + LEN_W + KW;
    localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_HASH    = 4'd2;
    localparam logic [3:0] S_PROBE   = 4'd3;
    localparam logic [3:0] S_CHK     = 4'd4;
    localparam logic [3:0] S_DEL     = 4'd5;
    localparam logic [3:0] S_DELCHK  = 4'd6;
    localparam logic [3:0] S_NEXT    = 4'd7;
    localparam logic [3:0] S_NEXTCHK = 4'd8;
    localparam logic [3:0] S_RESP    = 4'd9;

    // input word
    logic [FUNC_W-1:0] w_func;
    logic [KEY_W-1:0]  w_key_in;
    logic [LEN_W-1:0]  w_len_in;
    logic [SLOT_W-1:0] w_sin;
    logic [LEN_W-1:0]  w_len_c;
    logic [KEY_W-1:0]  w_key_m;
    logic              w_acc;

    assign w_func   = i_s_axis_tuser;
    assign w_key_in = i_s_axis_tdata[63:0];
    assign w_len_in = i_s_axis_tdata[67:64];
    assign w_sin    = i_s_axis_tdata[78:68];

    always_comb begin
        w_len_c = (32'(w_len_in) > KEY_BYTES) ? LEN_W'(KEY_BYTES) : w_len_in;
        for (int b = 0; b < 8; b++) begin
            w_key_m[b*8 +: 8] = (b < int'(w_len_c)) ? w_key_in[b*8 +: 8] : 8'd0;
        end
    end

    // control and working registers
    logic [3:0]        r_state;
    logic [AW-1:0]     r_idx;
    logic [AW:0]       r_cnt;
    logic              r_clr_resp;
    logic [AW:0]       r_live;
    logic              r_is_ins;
    logic [KW-1:0]     r_key;
    logic [LEN_W-1:0]  r_len;
    t_hash             r_hash;
    logic              r_have_tomb;
    logic [AW-1:0]     r_tomb;
    logic [STAT_W-1:0] r_res_status;
    logic [AW-1:0]     r_res_slot;
    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic [2:0]        r_out_status;

    logic  w_hash_start;
    logic  w_hash_done;
    t_hash w_hash;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_hash_start    = w_acc && (w_func == FN_LOOKUP || w_func == FN_INSERT);

    lpht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_key_m),
        .i_len   (w_len_c),
        .o_done  (w_hash_done),
        .o_hash  (w_hash)
    );

    // memories
    logic [1:0]    mark_mem [TABLE_SLOTS];
    logic [DW-1:0] data_mem [TABLE_SLOTS];
    logic [1:0]    r_mark_rd;
    logic [DW-1:0] r_data_rd;
    logic [AW-1:0] w_rd_addr;
    logic          w_mark_we;
    logic [AW-1:0] w_mark_wa;
    logic [1:0]    w_mark_wd;
    logic          w_data_we;

    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            mark_mem[w_mark_wa] <= w_mark_wd;
        end
        r_mark_rd <= mark_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            data_mem[w_mark_wa] <= {r_hash, r_len, r_key};
        end
        r_data_rd <= data_mem[w_rd_addr];
    end

    t_hash            w_st_hash;
    logic [LEN_W-1:0] w_st_len;
    logic [KW-1:0]    w_st_key;
    logic             w_match;
    logic             w_ins_now;
    logic             w_del_now;

    assign w_st_key  = r_data_rd[KW-1:0];
    assign w_st_len  = r_data_rd[KW +: LEN_W];
    assign w_st_hash = r_data_rd[KW+LEN_W +: HASH_W];
    assign w_match   = (w_st_hash == r_hash) && (w_st_len == r_len) && (w_st_key == r_key);

    // read address runs one slot ahead while checking
    assign w_rd_addr = (r_state == S_CHK || r_state == S_NEXTCHK) ? r_idx + 1'b1 : r_idx;

    assign w_ins_now = (r_state == S_CHK) && (r_mark_rd == MARK_EMPTY) && r_is_ins;
    assign w_del_now = (r_state == S_DELCHK) && (r_mark_rd == MARK_LIVE);

    always_comb begin
        w_mark_we = 1'b0;
        w_data_we = 1'b0;
        w_mark_wa = r_idx;
        w_mark_wd = MARK_EMPTY;
        if (r_state == S_CLEAR) begin
            w_mark_we = 1'b1;
        end else if (w_ins_now) begin
            w_mark_we = 1'b1;
            w_data_we = 1'b1;
            w_mark_wa = r_have_tomb ? r_tomb : r_idx;
            w_mark_wd = MARK_LIVE;
        end else if (w_del_now) begin
            w_mark_we = 1'b1;
            w_mark_wd = MARK_TOMB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_clr_resp  <= 1'b0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the response state loads the output word itself
            if (r_out_valid && i_m_axis_tready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_res_status <= ST_DONE;
                        r_res_slot   <= '0;
                        r_state      <= r_clr_resp ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_key       <= w_key_m[KW-1:0];
                        r_len       <= w_len_c;
                        r_is_ins    <= (w_func == FN_INSERT);
                        r_have_tomb <= 1'b0;
                        r_cnt       <= '0;
                        r_res_slot  <= '0;
                        unique case (w_func)
                            FN_LOOKUP, FN_INSERT: begin
                                r_state <= S_HASH;
                            end
                            FN_DELETE: begin
                                r_idx <= AW'(w_sin);
                                if (32'(w_sin) >= TABLE_SLOTS) begin
                                    r_res_status <= ST_BADSLOT;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_state <= S_DEL;
                                end
                            end
                            FN_ERASE: begin
                                r_idx      <= '0;
                                r_live     <= '0;
                                r_clr_resp <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            FN_NEXT: begin
                                r_idx <= AW'(w_sin);
                                if (32'(w_sin) >= TABLE_SLOTS) begin
                                    r_res_status <= ST_END;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_state <= S_NEXT;
                                end
                            end
                            default: begin
                                r_res_status <= ST_DONE;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_hash  <= w_hash;
                        r_idx   <= w_hash[AW-1:0];
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_mark_rd == MARK_EMPTY) begin
                        if (r_is_ins) begin
                            r_res_status <= ST_INSERTED;
                            r_res_slot   <= r_have_tomb ? r_tomb : r_idx;
                            r_live       <= r_live + 1'b1;
                        end else begin
                            r_res_status <= ST_ABSENT;
                        end
                        r_state <= S_RESP;
                    end else if (r_mark_rd != MARK_TOMB && w_match) begin
                        r_res_status <= ST_FOUND;
                        r_res_slot   <= r_idx;
                        r_state      <= S_RESP;
                    end else if (r_cnt == (AW+1)'(TABLE_SLOTS - 1)) begin
                        // whole table probed without an empty slot
                        r_res_status <= r_is_ins ? ST_NOROOM : ST_ABSENT;
                        r_state      <= S_RESP;
                    end else begin
                        if (r_mark_rd == MARK_TOMB && !r_have_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb      <= r_idx;
                        end
                        r_idx <= r_idx + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DEL: begin
                    r_state <= S_DELCHK;
                end
                S_DELCHK: begin
                    if (w_del_now) begin
                        r_res_status <= ST_DONE;
                        r_res_slot   <= r_idx;
                        r_live       <= r_live - 1'b1;
                    end else begin
                        r_res_status <= ST_BADSLOT;
                    end
                    r_state <= S_RESP;
                end
                S_NEXT: begin
                    r_state <= S_NEXTCHK;
                end
                S_NEXTCHK: begin
                    if (r_mark_rd == MARK_LIVE) begin
                        r_res_status <= ST_FOUND;
                        r_res_slot   <= r_idx;
                        r_state      <= S_RESP;
                    end else if (r_idx == LAST) begin
                        r_res_status <= ST_END;
                        r_state      <= S_RESP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_data   <= {3'd0, LIVE_W'(r_live), SOUT_W'(r_res_slot)};
                        r_clr_resp   <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= TABLE_SLOTS)
        else $error("live count beyond table size");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_now |=> r_live == $past(r_live) + 1'b1)
        else $error("insert did not bump live count");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_del_now |=> r_live == $past(r_live) - 1'b1)
        else $error("delete did not drop live count");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHK |-> 32'(r_cnt) < TABLE_SLOTS)
        else $error("probe ran past the table");
`endif

endmodule
